// ===== design/ppba_pkg.sv =====
package ppba_pkg;

    localparam int unsigned AddrW = 48;
    localparam int unsigned AlignW = 17;
    localparam int unsigned PropW = 9;
    localparam int unsigned NumPropRegs = 4;
    localparam int unsigned CfgIdxW = 3;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] CfgMinPage = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgPool0 = 3'd1;

    // Result status codes.
    localparam logic [1:0] StOk = 2'd0;
    localparam logic [1:0] StNoPool = 2'd1;
    localparam logic [1:0] StFull = 2'd2;
    localparam logic [1:0] StBadFree = 2'd3;

    localparam logic ActAlloc = 1'b0;

    typedef struct packed {
        logic              action;
        logic [3:0]        type_filter;
        logic [PropW-1:0]  required_props;
        logic [31:0]       elem_bytes;
        logic [15:0]       elem_count;
        logic [AlignW-1:0] align_bytes;
        logic [1:0]        free_pool;
        logic [2:0]        free_page;
        logic [AddrW-1:0]  free_offset;
    } t_req;

    typedef struct packed {
        logic [1:0]       status;
        logic [1:0]       pool_index;
        logic [2:0]       page_index;
        logic [AddrW-1:0] byte_offset;
        logic [AddrW-1:0] rounded_bytes;
        logic             new_page;
        logic [AddrW-1:0] new_page_bytes;
    } t_rsp;

    typedef enum logic [3:0] {
        S_IDLE, S_POOL, S_MUL, S_DIV, S_ROUND, S_SCAN, S_FREE, S_OPEN, S_BUMP, S_DONE
    } t_state;

    // Divider control and status.
    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

// ===== design/ppba_div.sv =====
// Restoring divider, one quotient bit per cycle; reports whether the
// dividend is an exact multiple of the divisor and the quotient.
module ppba_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ppba_pkg::t_div_ctl        i_ctl,
    input  logic [ppba_pkg::AddrW-1:0]  i_num,
    input  logic [ppba_pkg::AlignW-1:0] i_den,
    output ppba_pkg::t_div_sts        o_sts,
    output logic [ppba_pkg::AddrW-1:0]  o_quo,
    output logic                      o_exact
);
    import ppba_pkg::*;

    logic [AddrW-1:0]  r_quo;
    logic [AlignW:0]   r_rem;
    logic [AlignW-1:0] r_den;
    logic [5:0]        r_cnt;
    logic              r_busy, r_done;
    logic [AlignW:0]   w_try;
    logic [AlignW:0]   w_sh;

    // Shift in the next dividend bit and trial-subtract.
    assign w_sh  = {r_rem[AlignW-1:0], r_quo[AddrW-1]};
    assign w_try = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(AddrW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!w_try[AlignW]) begin
                r_rem <= w_try;
                r_quo <= {r_quo[AddrW-2:0], 1'b1};
            end else begin
                r_rem <= w_sh;
                r_quo <= {r_quo[AddrW-2:0], 1'b0};
            end
        end
    end

    assign o_sts   = '{busy: r_busy, done: r_done};
    assign o_quo   = r_quo;
    assign o_exact = (r_rem == '0);
endmodule

// ===== design/pooled_page_bump_allocator_top.sv =====
// Page-based bump allocator over NUM_POOLS pools of PAGES_PER_POOL page slots.
// One request is handled at a time and o_in_stall stays low only while idle.
// An allocate takes up to NUM_POOLS pool checks, a multiply step, the divider,
// a rounding step, a scan of up to 2*PAGES_PER_POOL slot visits, a step to open
// a page, a bump and a step to present the result. The next request is taken
// only after the result has left. The page table is held in registers and
// cleared at reset.
module pooled_page_bump_allocator_top #(
    parameter int unsigned NUM_POOLS      = 4,
    parameter int unsigned PAGES_PER_POOL = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  ppba_pkg::t_req                    i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output ppba_pkg::t_rsp                    o_out_data,
    input  logic                              i_cfg_we,
    input  logic [ppba_pkg::CfgIdxW-1:0]      i_cfg_idx,
    input  logic [ppba_pkg::AddrW-1:0]        i_cfg_data
);
    import ppba_pkg::*;

    localparam int unsigned Slots = NUM_POOLS * PAGES_PER_POOL;
    localparam int unsigned PoolW = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
    localparam int unsigned PageW = (PAGES_PER_POOL > 1) ? $clog2(PAGES_PER_POOL) : 1;
    localparam int unsigned SlotW = (Slots > 1) ? $clog2(Slots) : 1;

    // Configuration registers.
    logic [AddrW-1:0] r_min_page;
    logic [PropW-1:0] r_props [NumPropRegs];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_page <= AddrW'(65536);
            for (int i = 0; i < NumPropRegs; i++) r_props[i] <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CfgMinPage) r_min_page <= i_cfg_data;
            for (int i = 0; i < NumPropRegs; i++)
                if (i_cfg_idx == CfgPool0 + CfgIdxW'(i))
                    r_props[i] <= i_cfg_data[PropW-1:0];
        end
    end

    // Page table.
    logic               r_valid [Slots];
    logic [AddrW-1:0]   r_total [Slots];
    logic [AddrW-1:0]   r_left  [Slots];
    logic [AlignW-1:0]  r_palign[Slots];

    t_state r_state, n_state;
    t_req   r_req;
    t_rsp   r_rsp;
    logic [PoolW-1:0]  r_pool;
    logic [PoolW:0]    r_pcnt;
    logic [PageW:0]    r_page;
    logic              r_open_pass;
    logic [AlignW-1:0] r_align;
    logic [AddrW-1:0]  r_size;
    logic [SlotW-1:0]  r_slot;
    logic              r_opened;
    logic              r_out_valid;

    t_div_ctl         w_div_ctl;
    t_div_sts         w_div_sts;
    logic [AddrW-1:0] w_quo;
    logic             w_exact;
    logic [AddrW-1:0] w_prod;

    // Raw request size, handed to the divider as it starts.
    assign w_prod = AddrW'(r_req.elem_bytes) * AddrW'(r_req.elem_count);

    ppba_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_div_ctl),
        .i_num  (w_prod),
        .i_den  (r_align),
        .o_sts  (w_div_sts),
        .o_quo  (w_quo),
        .o_exact(w_exact)
    );

    // Per-cycle probes of the pool and slot being visited.
    logic [PropW-1:0] w_pprops;
    logic             w_pool_ok;
    logic [SlotW-1:0] w_sidx;
    logic             w_hit;
    logic             w_fslot_ok;
    logic [SlotW-1:0] w_fslot;

    always_comb begin
        w_pprops = '0;
        for (int i = 0; i < NumPropRegs; i++)
            if (int'(r_pool) == i) w_pprops = r_props[i];
        w_pool_ok = (r_pcnt < (PoolW+1)'(NUM_POOLS)) && (int'(r_pool) < 4)
                    && r_req.type_filter[2'(r_pool)]
                    && ((w_pprops & r_req.required_props) == r_req.required_props);
        w_sidx = SlotW'(int'(r_pool) * PAGES_PER_POOL + int'(r_page[PageW-1:0]));
        if (r_open_pass)
            w_hit = !r_valid[w_sidx];
        else
            w_hit = r_valid[w_sidx] && (r_left[w_sidx] >= r_size)
                    && (r_palign[w_sidx] == r_align);
        w_fslot_ok = (int'(r_req.free_pool) < NUM_POOLS)
                     && (int'(r_req.free_page) < PAGES_PER_POOL);
        w_fslot = SlotW'(int'(r_req.free_pool) * PAGES_PER_POOL + int'(r_req.free_page));
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid && !r_out_valid)
                         n_state = (i_in_data.action == ActAlloc) ? S_POOL : S_FREE;
            S_POOL:  if (w_pool_ok) n_state = S_MUL;
                     else if (r_pcnt >= (PoolW+1)'(NUM_POOLS - 1)) n_state = S_DONE;
            S_MUL:   n_state = S_DIV;
            S_DIV:   if (w_div_sts.done) n_state = S_ROUND;
            S_ROUND: n_state = S_SCAN;
            S_SCAN:  if (w_hit) n_state = r_open_pass ? S_OPEN : S_BUMP;
                     else if (r_page == (PageW+1)'(PAGES_PER_POOL - 1) && r_open_pass)
                         n_state = S_DONE;
            S_OPEN:  n_state = S_BUMP;
            S_BUMP:  n_state = S_DONE;
            S_FREE:  n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        o_in_stall      = !(r_state == S_IDLE && !r_out_valid);
        w_div_ctl.start = (r_state == S_MUL);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < Slots; i++) begin
                r_valid[i]  <= 1'b0;
                r_total[i]  <= '0;
                r_left[i]   <= '0;
                r_palign[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid && !r_out_valid) begin
                        r_req       <= i_in_data;
                        r_pool      <= '0;
                        r_pcnt      <= '0;
                        r_rsp       <= '0;
                        r_opened    <= 1'b0;
                        r_open_pass <= 1'b0;
                        r_page      <= '0;
                        r_align     <= (i_in_data.align_bytes == '0) ? AlignW'(1)
                                                                     : i_in_data.align_bytes;
                    end
                end
                S_POOL: begin
                    if (w_pool_ok) begin
                        r_rsp.pool_index <= 2'(r_pool);
                    end else if (r_pcnt >= (PoolW+1)'(NUM_POOLS - 1)) begin
                        r_rsp.status <= StNoPool;
                    end else begin
                        r_pool <= r_pool + PoolW'(1);
                        r_pcnt <= r_pcnt + (PoolW+1)'(1);
                    end
                end
                S_MUL:   r_size <= w_prod;
                S_DIV:   ;
                S_ROUND: r_size <= AddrW'((w_quo + AddrW'(!w_exact)) * r_align);
                S_SCAN: begin
                    if (w_hit) begin
                        r_slot <= w_sidx;
                        r_rsp.page_index <= 3'(r_page);
                    end else if (r_page == (PageW+1)'(PAGES_PER_POOL - 1)) begin
                        r_page <= '0;
                        if (r_open_pass) begin
                            r_rsp.status        <= StFull;
                            r_rsp.rounded_bytes <= r_size;
                        end else r_open_pass <= 1'b1;
                    end else r_page <= r_page + (PageW+1)'(1);
                end
                S_OPEN: begin
                    r_valid[r_slot]  <= 1'b1;
                    r_total[r_slot]  <= (r_size > r_min_page) ? r_size : r_min_page;
                    r_left[r_slot]   <= (r_size > r_min_page) ? r_size : r_min_page;
                    r_palign[r_slot] <= r_align;
                    r_opened         <= 1'b1;
                end
                S_BUMP: begin
                    r_rsp.status         <= StOk;
                    r_rsp.byte_offset    <= r_total[r_slot] - r_left[r_slot];
                    r_rsp.rounded_bytes  <= r_size;
                    r_rsp.new_page       <= r_opened;
                    r_rsp.new_page_bytes <= r_opened ? r_total[r_slot] : '0;
                    r_left[r_slot]       <= r_left[r_slot] - r_size;
                end
                S_FREE: begin
                    r_rsp.pool_index  <= r_req.free_pool;
                    r_rsp.page_index  <= r_req.free_page;
                    r_rsp.byte_offset <= r_req.free_offset;
                    if (w_fslot_ok && r_valid[w_fslot]) begin
                        r_rsp.status <= StOk;
                        r_left[w_fslot] <= (r_req.free_offset <= r_total[w_fslot])
                                           ? r_total[w_fslot] - r_req.free_offset : '0;
                    end else r_rsp.status <= StBadFree;
                end
                S_DONE:  r_out_valid <= 1'b1;
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_rsp;
endmodule

// ===== bench/tb.sv =====
module tb;
    import ppba_pkg::*;

    localparam logic ActFree = ~ActAlloc;
    localparam int unsigned Slots = 32;
    localparam int unsigned Pages = 8;
    localparam logic [AddrW-1:0] AddrMax = {AddrW{1'b1}};

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    t_req             in_data = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    t_rsp             out_data;
    logic             cfg_we = 1'b0;
    logic [CfgIdxW-1:0] cfg_idx = '0;
    logic [AddrW-1:0] cfg_data = '0;

    pooled_page_bump_allocator_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Shadow copy of the allocator's configuration and page table.
    logic [AddrW-1:0]  min_page;
    logic [PropW-1:0]  pool_flags [NumPropRegs];
    logic              slot_valid [Slots];
    logic [63:0]       slot_total [Slots];
    logic [63:0]       slot_left  [Slots];
    logic [AlignW-1:0] slot_align [Slots];

    t_req pending_reqs [$];
    t_rsp expected_rsps [$];
    t_rsp granted [$];

    int errors = 0;
    int n_ok_alloc = 0, n_no_pool = 0, n_full = 0, n_ok_free = 0, n_bad_free = 0;
    int n_opened = 0;
    int send_gap = 0, stall_left = 0;
    bit quiet = 1'b0;

    // Computes the response of one request and updates the shadow page table.
    function automatic t_rsp allocate_or_free(t_req r);
        t_rsp rsp;
        int pool, pg, s;
        logic [63:0] size, q, al, total;
        bit hit;
        rsp = '0;
        if (r.action == ActAlloc) begin
            pool = -1;
            for (int i = 0; i < NumPropRegs; i++) begin
                if (pool < 0 && r.type_filter[i]
                        && (pool_flags[i] & r.required_props) == r.required_props) begin
                    pool = i;
                end
            end
            if (pool < 0) begin
                rsp.status = StNoPool;
                n_no_pool++;
                return rsp;
            end
            al = (r.align_bytes == 0) ? 64'd1 : 64'(r.align_bytes);
            size = 64'(r.elem_bytes) * 64'(r.elem_count);
            q = size / al;
            if (size % al != 0) q++;
            size = q * al;
            rsp.pool_index = pool[1:0];
            rsp.rounded_bytes = size[AddrW-1:0];
            hit = 1'b0;
            pg = 0;
            // Reuse the lowest page with room and the same alignment.
            for (int p = 0; p < Pages; p++) begin
                s = pool * Pages + p;
                if (!hit && slot_valid[s] && slot_left[s] >= size
                        && 64'(slot_align[s]) == al) begin
                    hit = 1'b1;
                    pg = p;
                end
            end
            if (!hit) begin
                for (int p = 0; p < Pages; p++) begin
                    if (!hit && !slot_valid[pool * Pages + p]) begin
                        hit = 1'b1;
                        pg = p;
                    end
                end
                if (!hit) begin
                    rsp.status = StFull;
                    n_full++;
                    return rsp;
                end
                s = pool * Pages + pg;
                total = (size > 64'(min_page)) ? size : 64'(min_page);
                slot_valid[s] = 1'b1;
                slot_total[s] = total;
                slot_left[s] = total;
                slot_align[s] = al[AlignW-1:0];
                rsp.new_page = 1'b1;
                rsp.new_page_bytes = total[AddrW-1:0];
                n_opened++;
            end
            s = pool * Pages + pg;
            rsp.status = StOk;
            rsp.page_index = pg[2:0];
            rsp.byte_offset = AddrW'(slot_total[s] - slot_left[s]);
            slot_left[s] = slot_left[s] - size;
            n_ok_alloc++;
            granted.push_back(rsp);
            if (granted.size() > 64) void'(granted.pop_front());
        end else begin
            s = int'(r.free_pool) * Pages + int'(r.free_page);
            rsp.pool_index = r.free_pool;
            rsp.page_index = r.free_page;
            rsp.byte_offset = r.free_offset;
            if (!slot_valid[s]) begin
                rsp.status = StBadFree;
                n_bad_free++;
            end else begin
                slot_left[s] = (64'(r.free_offset) <= slot_total[s])
                    ? slot_total[s] - 64'(r.free_offset) : 64'd0;
                rsp.status = StOk;
                n_ok_free++;
            end
        end
        return rsp;
    endfunction

    // Mostly short gaps, a few long ones, none during quiet stretches.
    function automatic int idle_len();
        int k;
        k = $urandom_range(0, 99);
        if (quiet || k < 60) return 0;
        if (k < 94) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Request driver: one transaction at a time from the pending queue.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                expected_rsps.push_back(allocate_or_free(in_data));
            end
            if (!in_valid || !in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    in_data <= pending_reqs.pop_front();
                    in_valid <= 1'b1;
                    send_gap = idle_len();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor and random back-pressure.
    always @(posedge i_clk) begin
        if (out_valid && !out_stall) begin
            if (expected_rsps.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected response %h", out_data);
            end else begin
                t_rsp e;
                e = expected_rsps.pop_front();
                if (out_data.status !== e.status || out_data.pool_index !== e.pool_index
                        || out_data.page_index !== e.page_index
                        || out_data.byte_offset !== e.byte_offset
                        || out_data.rounded_bytes !== e.rounded_bytes
                        || out_data.new_page !== e.new_page
                        || out_data.new_page_bytes !== e.new_page_bytes) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("mismatch: expected st=%0d pool=%0d page=%0d off=%h rnd=%h np=%0d npb=%h",
                            e.status, e.pool_index, e.page_index, e.byte_offset,
                            e.rounded_bytes, e.new_page, e.new_page_bytes);
                        $display("          actual   st=%0d pool=%0d page=%0d off=%h rnd=%h np=%0d npb=%h",
                            out_data.status, out_data.pool_index, out_data.page_index,
                            out_data.byte_offset, out_data.rounded_bytes,
                            out_data.new_page, out_data.new_page_bytes);
                    end
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else begin
            stall_left = idle_len();
            out_stall <= (stall_left > 0);
        end
    end

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [AddrW-1:0] val);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        if (idx == CfgMinPage) min_page = val;
        else pool_flags[idx - CfgPool0] = val[PropW-1:0];
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Waits until every request is sent and every response is in, then lets the block settle.
    task automatic drain();
        while (pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    function automatic t_req alloc_req(logic [3:0] filt, logic [PropW-1:0] req,
                                       logic [31:0] eb, logic [15:0] ec,
                                       logic [AlignW-1:0] al);
        t_req r;
        r = '0;
        r.action = ActAlloc;
        r.type_filter = filt;
        r.required_props = req;
        r.elem_bytes = eb;
        r.elem_count = ec;
        r.align_bytes = al;
        return r;
    endfunction

    function automatic t_req free_req(logic [1:0] pool, logic [2:0] pg, logic [AddrW-1:0] off);
        t_req r;
        r = '0;
        r.action = ActFree;
        r.free_pool = pool;
        r.free_page = pg;
        r.free_offset = off;
        return r;
    endfunction

    function automatic logic [AlignW-1:0] pick_align();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 17'd1;
            2: return 17'd2;
            3: return 17'd8;
            4: return 17'd64;
            5: return 17'd4096;
            6: return 17'd65536;
            7: return 17'($urandom_range(1, 131071));
            default: return 17'(1 << $urandom_range(0, 4));
        endcase
    endfunction

    // One random request: mostly well-formed allocations and frees, some noise.
    function automatic t_req random_req();
        t_req r;
        int k, pool;
        t_rsp g;
        k = $urandom_range(0, 99);
        if (k < 60) begin
            pool = $urandom_range(0, NumPropRegs - 1);
            r = alloc_req(4'($urandom_range(1, 15)) | (4'd1 << pool),
                          pool_flags[pool] & PropW'($urandom), 32'($urandom_range(0, 300)),
                          16'($urandom_range(0, 20)), pick_align());
            if ($urandom_range(0, 19) == 0) begin
                r.elem_bytes = $urandom;
                r.elem_count = 16'($urandom);
            end
        end else if (k < 85 && granted.size() > 0) begin
            g = granted[$urandom_range(0, granted.size() - 1)];
            r = free_req(g.pool_index, g.page_index, g.byte_offset);
            if ($urandom_range(0, 9) == 0) r.free_offset = {16'($urandom), 32'($urandom)};
        end else begin
            r = {4'($urandom), $urandom, $urandom, $urandom, $urandom};
        end
        return r;
    endfunction

    initial begin
        logic [AddrW-1:0] min_vals [5];
        min_page = 48'd65536;
        foreach (pool_flags[i]) pool_flags[i] = '0;
        foreach (slot_valid[i]) begin
            slot_valid[i] = 1'b0;
            slot_total[i] = '0;
            slot_left[i] = '0;
            slot_align[i] = '0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: pool selection, extremes, full table and frees.
        write_reg(CfgMinPage, 48'd256);
        write_reg(CfgPool0, 48'h1FF);
        write_reg(CfgPool0 + CfgIdxW'(1), 48'h000);
        write_reg(CfgPool0 + CfgIdxW'(2), 48'h0A5);
        write_reg(CfgPool0 + CfgIdxW'(3), 48'h15A);
        quiet = 1'b1;
        pending_reqs.push_back(alloc_req(4'h0, 9'h000, 32'd4, 16'd4, 17'd4));
        pending_reqs.push_back(alloc_req(4'hE, 9'h1FF, 32'd4, 16'd4, 17'd4));
        pending_reqs.push_back(alloc_req(4'h1, 9'h1FF, 32'hFFFF_FFFF, 16'hFFFF, 17'd65536));
        pending_reqs.push_back(alloc_req(4'h1, 9'h000, 32'd0, 16'd7, 17'd1));
        pending_reqs.push_back(alloc_req(4'h1, 9'h000, 32'd3, 16'd5, 17'd0));
        pending_reqs.push_back(alloc_req(4'h1, 9'h000, 32'd3, 16'd5, 17'd1));
        pending_reqs.push_back(alloc_req(4'h1, 9'h000, 32'd10, 16'd1, 17'd1));
        for (int i = 2; i < 9; i++)
            pending_reqs.push_back(alloc_req(4'hF, 9'h000, 32'd5, 16'd3, 17'(1 << i)));
        pending_reqs.push_back(alloc_req(4'h1, 9'h001, 32'd1, 16'd1, 17'h1FFFF));
        pending_reqs.push_back(alloc_req(4'hC, 9'h0A5, 32'd100, 16'd0, 17'd16));
        pending_reqs.push_back(free_req(2'd3, 3'd7, 48'd0));
        pending_reqs.push_back(free_req(2'd0, 3'd2, 48'd0));
        pending_reqs.push_back(free_req(2'd0, 3'd2, AddrMax));
        pending_reqs.push_back(free_req(2'd0, 3'd1, 48'd15));
        pending_reqs.push_back(alloc_req(4'h1, 9'h000, 32'd3, 16'd5, 17'd1));
        drain();
        quiet = 1'b0;

        // Random phases under different page sizes and pool flags.
        min_vals[0] = 48'd65536;
        min_vals[1] = 48'd1;
        min_vals[2] = AddrMax;
        min_vals[3] = 48'd64;
        min_vals[4] = 48'd4096;
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(CfgMinPage, min_vals[ph]);
            for (int i = 0; i < NumPropRegs; i++) begin
                write_reg(CfgPool0 + CfgIdxW'(i),
                          AddrW'((ph == 0) ? 9'h1FF : (ph == 1) ? 9'h000 : PropW'($urandom)));
            end
            quiet = (ph == 3);
            for (int n = 0; n < 250; n++) begin
                while (pending_reqs.size() > 3) @(posedge i_clk);
                pending_reqs.push_back(random_req());
            end
            drain();
        end

        if (expected_rsps.size() != 0) errors++;
        $display("covered %0d good allocations (%0d new pages), %0d no-pool, %0d table-full,",
            n_ok_alloc, n_opened, n_no_pool, n_full);
        $display("%0d good frees and %0d bad frees over six configurations", n_ok_free, n_bad_free);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== pooled_page_bump_allocator_top.f =====
design/ppba_pkg.sv
design/ppba_div.sv
design/pooled_page_bump_allocator_top.sv
bench/tb.sv
